@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the rtl top level of the mapper core
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/bshm_pkg.sv @@
// bshm_pkg: frame geometry, widths, coefficient codes and shared types
// used by every module of the bright spot homography mapper
`default_nettype none

package bshm_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;

    localparam int COL_W = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
    localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
    localparam int CNT_W = (COL_W > ROW_W) ? COL_W : ROW_W;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 48;
    localparam int NUM_COEF   = 8;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);
    localparam int CFG_IDX_W  = 4;
    localparam int ACC_W      = 64;
    localparam int PROD_W     = COEF_W + CNT_W + 1;
    localparam int OUT_W      = 32;
    localparam int SCOL_W     = 10;
    localparam int SROW_W     = 9;

    localparam int NUM_TERMS = 6;
    localparam int DIV_BITS  = 32;
    localparam int STEP_W    = $clog2(DIV_BITS);

    localparam logic [COEF_W-1:0] ONE_Q24 = COEF_W'(16777216);

    typedef enum logic [COEF_IDX_W-1:0] {
        COEF_XX = 3'd0,
        COEF_XY = 3'd1,
        COEF_XT = 3'd2,
        COEF_YX = 3'd3,
        COEF_YY = 3'd4,
        COEF_YT = 3'd5,
        COEF_ZX = 3'd6,
        COEF_ZY = 3'd7
    } t_coef_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV_LOAD,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_DIV_DONE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_spot;

    typedef struct packed {
        logic       launch;
        logic       mul;
        logic       acc;
        logic [2:0] term;
        logic       zero_res;
        logic       div_load;
        logic       div_init;
        logic       div_step;
        logic       div_done;
        logic       div_sel;
        logic       load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic den_zero;
        logic out_free;
    } t_dp_status;

    // product term order: x col, x row, y col, y row, z col, z row
    function automatic t_coef_idx term_coef(input logic [2:0] term);
        t_coef_idx c;
        case (term)
            3'd0:    c = COEF_XX;
            3'd1:    c = COEF_XY;
            3'd2:    c = COEF_YX;
            3'd3:    c = COEF_YY;
            3'd4:    c = COEF_ZX;
            3'd5:    c = COEF_ZY;
            default: c = COEF_XX;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bshm_tracker.sv @@
// bshm_tracker: raster counters and first-brightest-pixel tracking
// depends on bshm_pkg
`default_nettype none

module bshm_tracker import bshm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [PIX_W-1:0] i_pixel,
    input  wire logic             i_end_of_frame,
    output t_spot                 o_spot
);

    logic [PIX_W-1:0] r_best_level, n_best_level;
    logic [COL_W-1:0] r_best_col, n_best_col;
    logic [ROW_W-1:0] r_best_row, n_best_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_first, n_first;
    logic             w_take;

    // best spot including the current pixel
    always_comb begin
        w_take = r_first || (i_pixel > r_best_level);
        o_spot.level = w_take ? i_pixel : r_best_level;
        o_spot.col   = w_take ? r_col : r_best_col;
        o_spot.row   = w_take ? r_row : r_best_row;
    end

    always_comb begin
        n_best_level = r_best_level;
        n_best_col   = r_best_col;
        n_best_row   = r_best_row;
        n_col        = r_col;
        n_row        = r_row;
        n_first      = r_first;
        if (i_accept) begin
            n_best_level = o_spot.level;
            n_best_col   = o_spot.col;
            n_best_row   = o_spot.row;
            n_first      = 1'b0;
            if (i_end_of_frame) begin
                n_best_level = '0;
                n_col        = '0;
                n_row        = '0;
                n_first      = 1'b1;
            end else if (r_col == COL_LAST) begin
                n_col = '0;
                n_row = (r_row == ROW_LAST) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_level <= '0;
            r_best_col   <= '0;
            r_best_row   <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_first      <= 1'b1;
        end else begin
            r_best_level <= n_best_level;
            r_best_col   <= n_best_col;
            r_best_row   <= n_best_row;
            r_col        <= n_col;
            r_row        <= n_row;
            r_first      <= n_first;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bshm_ctrl.sv @@
// bshm_ctrl: sequencer for the per-frame mapping (multiply, check, divide, emit)
// depends on bshm_pkg; drives the datapath through t_dp_cmd
`default_nettype none

module bshm_ctrl import bshm_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_busy
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_MUL;
                    n_cnt   = '0;
                end
            end
            ST_MUL: begin
                if (r_cnt == STEP_W'(NUM_TERMS)) begin
                    n_state = ST_CHECK;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_CHECK: begin
                n_sel   = 1'b0;
                n_state = i_status.den_zero ? ST_EMIT : ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                n_state = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                n_state = ST_DIV_RUN;
                n_cnt   = '0;
            end
            ST_DIV_RUN: begin
                if (r_cnt == STEP_W'(DIV_BITS - 1)) begin
                    n_state = ST_DIV_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DIV_DONE: begin
                if (r_sel) begin
                    n_state = ST_EMIT;
                end else begin
                    n_sel   = 1'b1;
                    n_state = ST_DIV_LOAD;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.term     = r_cnt[2:0];
        o_cmd.div_sel  = r_sel;
        o_busy         = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.launch = i_start;
            end
            ST_MUL: begin
                // product for term cnt, accumulate the one before it
                o_cmd.mul = (r_cnt != STEP_W'(NUM_TERMS));
                o_cmd.acc = (r_cnt != '0);
            end
            ST_CHECK: begin
                o_cmd.zero_res = i_status.den_zero;
            end
            ST_DIV_LOAD: begin
                o_cmd.div_load = 1'b1;
            end
            ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
            end
            ST_DIV_RUN: begin
                o_cmd.div_step = 1'b1;
            end
            ST_DIV_DONE: begin
                o_cmd.div_done = 1'b1;
            end
            ST_EMIT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bshm_map_dp.sv @@
// bshm_map_dp: coefficient registers, shared multiplier, accumulators,
// bit-serial divider and result register; depends on bshm_pkg
`default_nettype none

module bshm_map_dp import bshm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [COEF_W-1:0]     i_cfg_data,
    input  wire t_spot                 i_spot,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic signed [OUT_W-1:0]    o_world_x,
    output logic signed [OUT_W-1:0]    o_world_y,
    output logic [SCOL_W-1:0]          o_spot_col,
    output logic [SROW_W-1:0]          o_spot_row,
    output logic [PIX_W-1:0]           o_spot_level,
    output logic                       o_degenerate
);

    logic signed [COEF_W-1:0] r_coef [NUM_COEF];
    t_spot                    r_spot;
    logic signed [PROD_W-1:0] r_prod;
    logic [2:0]               r_prod_term;
    logic signed [ACC_W-1:0]  r_acc_x, r_acc_y, r_acc_z;

    logic                     r_neg, r_sat;
    logic [ACC_W-1:0]         r_n_mag, r_d_mag;
    logic [ACC_W-1:0]         r_rem;
    logic [DIV_BITS-1:0]      r_nbits, r_q;
    logic signed [OUT_W-1:0]  r_wx, r_wy;
    logic                     r_degen;

    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out_wx, r_out_wy;
    logic [SCOL_W-1:0]        r_out_col;
    logic [SROW_W-1:0]        r_out_row;
    logic [PIX_W-1:0]         r_out_level;

    logic signed [COEF_W-1:0] w_coef;
    logic [CNT_W-1:0]         w_opnd;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_prod_ext;
    logic signed [ACC_W-1:0]  w_num;
    logic [ACC_W:0]           w_trial;
    logic [ACC_W:0]           w_diff;
    logic                     w_ge;
    logic signed [OUT_W-1:0]  w_res;

    always_comb begin
        w_coef     = r_coef[term_coef(i_cmd.term)];
        w_opnd     = i_cmd.term[0] ? CNT_W'(r_spot.row) : CNT_W'(r_spot.col);
        w_prod     = w_coef * $signed({1'b0, w_opnd});
        w_prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        w_num      = i_cmd.div_sel ? r_acc_y : r_acc_x;
    end

    // one restoring step on the magnitudes
    always_comb begin
        w_trial = {r_rem, r_nbits[DIV_BITS-1]};
        w_ge    = (w_trial >= {1'b0, r_d_mag});
        w_diff  = w_trial - {1'b0, r_d_mag};
    end

    // sign and saturate the Q.16 quotient
    always_comb begin
        if (r_sat) begin
            w_res = r_neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else if (r_neg) begin
            w_res = (r_q > {1'b1, {(OUT_W-1){1'b0}}}) ? {1'b1, {(OUT_W-1){1'b0}}}
                                                     : -$signed(r_q);
        end else begin
            w_res = r_q[OUT_W-1] ? {1'b0, {(OUT_W-1){1'b1}}} : $signed(r_q);
        end
    end

    always_comb begin
        o_status.den_zero = (r_acc_z == '0);
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[COEF_XX] <= ONE_Q24;
            r_coef[COEF_XY] <= '0;
            r_coef[COEF_XT] <= '0;
            r_coef[COEF_YX] <= '0;
            r_coef[COEF_YY] <= ONE_Q24;
            r_coef[COEF_YT] <= '0;
            r_coef[COEF_ZX] <= '0;
            r_coef[COEF_ZY] <= '0;
        end else if (i_cfg_we && (i_cfg_index < CFG_IDX_W'(NUM_COEF))) begin
            r_coef[i_cfg_index[COEF_IDX_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.launch) begin
            r_spot  <= i_spot;
            r_acc_x <= {{(ACC_W-COEF_W){r_coef[COEF_XT][COEF_W-1]}}, r_coef[COEF_XT]};
            r_acc_y <= {{(ACC_W-COEF_W){r_coef[COEF_YT][COEF_W-1]}}, r_coef[COEF_YT]};
            r_acc_z <= {{(ACC_W-COEF_W){1'b0}}, ONE_Q24};
            r_degen <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_prod      <= w_prod;
            r_prod_term <= i_cmd.term;
        end
        if (i_cmd.acc) begin
            case (r_prod_term[2:1])
                2'd0:    r_acc_x <= r_acc_x + w_prod_ext;
                2'd1:    r_acc_y <= r_acc_y + w_prod_ext;
                default: r_acc_z <= r_acc_z + w_prod_ext;
            endcase
        end
        if (i_cmd.zero_res) begin
            r_wx    <= '0;
            r_wy    <= '0;
            r_degen <= 1'b1;
        end
        if (i_cmd.div_load) begin
            r_neg   <= w_num[ACC_W-1] ^ r_acc_z[ACC_W-1];
            r_n_mag <= w_num[ACC_W-1] ? -w_num : w_num;
            r_d_mag <= r_acc_z[ACC_W-1] ? -r_acc_z : r_acc_z;
        end
        if (i_cmd.div_init) begin
            // an integer part wider than 16 bits saturates
            r_sat   <= ({16'b0, r_n_mag} >= {r_d_mag, 16'b0});
            r_rem   <= {16'b0, r_n_mag[ACC_W-1:16]};
            r_nbits <= {r_n_mag[15:0], 16'b0};
            r_q     <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem   <= w_ge ? w_diff[ACC_W-1:0] : w_trial[ACC_W-1:0];
            r_q     <= {r_q[DIV_BITS-2:0], w_ge};
            r_nbits <= {r_nbits[DIV_BITS-2:0], 1'b0};
        end
        if (i_cmd.div_done) begin
            if (i_cmd.div_sel) begin
                r_wy <= w_res;
            end else begin
                r_wx <= w_res;
            end
        end
        if (i_cmd.load_out) begin
            r_out_wx    <= r_wx;
            r_out_wy    <= r_wy;
            r_out_col   <= SCOL_W'(r_spot.col);
            r_out_row   <= SROW_W'(r_spot.row);
            r_out_level <= r_spot.level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    logic r_out_degen;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_degen <= r_degen;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_world_x    = r_out_wx;
    assign o_world_y    = r_out_wy;
    assign o_spot_col   = r_out_col;
    assign o_spot_row   = r_out_row;
    assign o_spot_level = r_out_level;
    assign o_degenerate = r_out_degen;

endmodule

`default_nettype wire

@@ hw/rtl/bright_spot_homography_mapper_core.sv @@
// Bright spot homography mapper, top level.
// Pixel channel: i_in_valid / o_in_stall with i_pixel and i_end_of_frame,
// one word per cycle in raster order; i_end_of_frame marks a frame's last pixel.
// Result channel: o_out_valid / i_out_stall, one word per frame carrying the
// first brightest pixel's column, row and level and its world x / y (Q15.16).
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index 0..7
// selects a Q23.24 coefficient; other indexes are ignored. Write only when idle.
// Throughput: one pixel per cycle while no stall is raised. The end-of-frame pixel
// starts the mapping sequencer: products through the one shared multiplier, a
// check, then two passes of the bit-serial divider (skipped when the denominator
// is zero), then the load of the output register.
// An end-of-frame pixel that arrives while a mapping is still running is
// stalled until the sequencer is idle; other pixels are never stalled.
// A stalled result holds in the output register; the sequencer waits in its
// final step until that register frees up.
// Reset (synchronous, active low) restores the identity coefficients, clears
// the counters and the tracker, and drops any pending result.
`default_nettype none
`include "assert_macros.svh"

module bright_spot_homography_mapper_core import bshm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [PIX_W-1:0]      i_pixel,
    input  wire logic                  i_end_of_frame,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic signed [OUT_W-1:0]    o_world_x,
    output logic signed [OUT_W-1:0]    o_world_y,
    output logic [SCOL_W-1:0]          o_spot_col,
    output logic [SROW_W-1:0]          o_spot_row,
    output logic [PIX_W-1:0]           o_spot_level,
    output logic                       o_degenerate,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [COEF_W-1:0]     i_cfg_data
);

    logic       w_busy;
    logic       w_accept;
    logic       w_start;
    t_spot      w_spot;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_in_stall  = w_busy && i_end_of_frame;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_start     = w_accept && i_end_of_frame;

    bshm_tracker u_tracker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_pixel        (i_pixel),
        .i_end_of_frame (i_end_of_frame),
        .o_spot         (w_spot)
    );

    bshm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy)
    );

    bshm_map_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_spot       (w_spot),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_world_x    (o_world_x),
        .o_world_y    (o_world_y),
        .o_spot_col   (o_spot_col),
        .o_spot_row   (o_spot_row),
        .o_spot_level (o_spot_level),
        .o_degenerate (o_degenerate)
    );

    // a frame end always hands the spot to the sequencer
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, w_start, w_busy)
    // the result register is never overwritten while a word waits
    `ASSERT_IMPLIES(a_load_free, i_clk, i_rst_n, w_cmd.load_out, !o_out_valid || !i_out_stall)
    // a degenerate word carries zero coordinates
    `ASSERT_IMPLIES(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_degenerate,
        (o_world_x == '0) && (o_world_y == '0))

endmodule

`default_nettype wire

@@ sim/tb_bright_spot_homography_mapper_core.sv @@
// testbench for bright_spot_homography_mapper_core: drives frames of pixels and
// coefficient writes, predicts each frame's mapped spot and checks every result word
// depends on bshm_pkg and the rtl of the mapper core
`default_nettype none

module tb_bright_spot_homography_mapper_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bshm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 3;
    localparam int MAP_LATENCY   = 100;
    localparam int LONG_HOLD     = 400;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_PIXELS  = 68;
    localparam int PHASE_FRAMES  = 8;
    localparam int PRINT_CAP     = 100;
    localparam longint TIMEOUT_NS = 64'd2_000_000;

    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = CFG_IDX_W'(NUM_COEF);
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = '1;

    typedef enum int {PX_ANY, PX_LOW, PX_BINARY, PX_SPARSE} t_pix_mix;

    typedef struct packed {
        logic signed [OUT_W-1:0] wx;
        logic signed [OUT_W-1:0] wy;
        logic [SCOL_W-1:0]       col;
        logic [SROW_W-1:0]       row;
        logic [PIX_W-1:0]        level;
        logic                    degen;
    } t_map_result;

    class spot_map_predictor;
        longint           coef [NUM_COEF];
        logic [PIX_W-1:0] best_lvl;
        int               best_c;
        int               best_r;
        int               col_at;
        int               row_at;
        bit               fresh;
        t_map_result      pending_maps[$];
        int               mismatches;

        function new();
            foreach (coef[k]) coef[k] = 0;
            coef[COEF_XX] = longint'($signed(ONE_Q24));
            coef[COEF_YY] = longint'($signed(ONE_Q24));
            best_lvl   = '0;
            best_c     = 0;
            best_r     = 0;
            col_at     = 0;
            row_at     = 0;
            fresh      = 1'b1;
            mismatches = 0;
        endfunction

        function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
            if (idx < NUM_COEF)
                coef[idx] = longint'($signed(data));
        endfunction

        // signed quotient in Q.16, truncated toward zero, saturated to 32 bits
        function logic [OUT_W-1:0] q16_quotient(longint num, longint den);
            logic [63:0] n;
            logic [63:0] d;
            logic [79:0] q;
            bit          neg;
            neg = (num < 0) != (den < 0);
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            q = {n, 16'h0} / {16'h0, d};
            if (neg) begin
                if (q > 80'h8000_0000)
                    q = 80'h8000_0000;
                return -q[OUT_W-1:0];
            end
            if (q > 80'h7FFF_FFFF)
                q = 80'h7FFF_FFFF;
            return q[OUT_W-1:0];
        endfunction

        function void track_pixel(logic [PIX_W-1:0] pix, logic eof);
            t_map_result r;
            longint      nx;
            longint      ny;
            longint      dz;
            if (fresh || pix > best_lvl) begin
                best_lvl = pix;
                best_c   = col_at;
                best_r   = row_at;
            end
            fresh = 1'b0;
            if (!eof) begin
                col_at++;
                if (col_at >= FRAME_WIDTH) begin
                    col_at = 0;
                    row_at++;
                    if (row_at >= FRAME_HEIGHT)
                        row_at = 0;
                end
                return;
            end
            nx = best_c * coef[COEF_XX] + best_r * coef[COEF_XY] + coef[COEF_XT];
            ny = best_c * coef[COEF_YX] + best_r * coef[COEF_YY] + coef[COEF_YT];
            dz = best_c * coef[COEF_ZX] + best_r * coef[COEF_ZY]
                 + longint'($signed(ONE_Q24));
            if (dz == 0) begin
                r.wx    = '0;
                r.wy    = '0;
                r.degen = 1'b1;
            end else begin
                r.wx    = q16_quotient(nx, dz);
                r.wy    = q16_quotient(ny, dz);
                r.degen = 1'b0;
            end
            r.col   = best_c[SCOL_W-1:0];
            r.row   = best_r[SROW_W-1:0];
            r.level = best_lvl;
            pending_maps.push_back(r);
            best_lvl = '0;
            col_at   = 0;
            row_at   = 0;
            fresh    = 1'b1;
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_CAP)
                $display("%0t mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_field(string name, longint got, longint want);
            if (got != want)
                report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_map(t_map_result got);
            t_map_result want;
            if (pending_maps.size() == 0) begin
                report_mismatch($sformatf("unexpected word col %0d row %0d",
                                          got.col, got.row));
                return;
            end
            want = pending_maps.pop_front();
            check_field("world_x", got.wx, want.wx);
            check_field("world_y", got.wy, want.wy);
            check_field("spot_col", got.col, want.col);
            check_field("spot_row", got.row, want.row);
            check_field("spot_level", got.level, want.level);
            check_field("degenerate", got.degen, want.degen);
        endtask
    endclass

    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         i_in_valid     = 1'b0;
    logic                         o_in_stall;
    logic [PIX_W-1:0]             i_pixel        = '0;
    logic                         i_end_of_frame = 1'b0;
    logic                         o_out_valid;
    logic                         i_out_stall    = 1'b0;
    logic signed [OUT_W-1:0]      o_world_x;
    logic signed [OUT_W-1:0]      o_world_y;
    logic [SCOL_W-1:0]            o_spot_col;
    logic [SROW_W-1:0]            o_spot_row;
    logic [PIX_W-1:0]             o_spot_level;
    logic                         o_degenerate;
    logic                         i_cfg_valid    = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index    = '0;
    logic [COEF_W-1:0]            i_cfg_data     = '0;

    spot_map_predictor mapper;
    logic [COEF_W-1:0] coef_set [NUM_COEF];
    bit                idle_on       = 1'b0;
    logic              long_hold_req = 1'b0;
    bit                hold_taken    = 1'b0;
    int                hold_left     = 0;
    int                burst_left    = 0;

    bright_spot_homography_mapper_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel        (i_pixel),
        .i_end_of_frame (i_end_of_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_world_x      (o_world_x),
        .o_world_y      (o_world_y),
        .o_spot_col     (o_spot_col),
        .o_spot_row     (o_spot_row),
        .o_spot_level   (o_spot_level),
        .o_degenerate   (o_degenerate),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: check accepted words, then pick the stall for the next cycle
    always @(posedge i_clk) begin : result_side
        t_map_result seen;
        bit          stall_next;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.wx    = o_world_x;
            seen.wy    = o_world_y;
            seen.col   = o_spot_col;
            seen.row   = o_spot_row;
            seen.level = o_spot_level;
            seen.degen = o_degenerate;
            mapper.check_map(seen);
        end
        if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD - 1;
            stall_next = 1'b1;
        end else if (burst_left != 0) begin
            burst_left--;
            stall_next = 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(1, 5) - 1;
            stall_next = 1'b1;
        end else begin
            stall_next = 1'b0;
        end
        i_out_stall <= stall_next;
    end

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic eof);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_pixel        <= pix;
        i_end_of_frame <= eof;
        do @(posedge i_clk); while (o_in_stall);
        mapper.track_pixel(pix, eof);
    endtask

    function automatic logic [PIX_W-1:0] draw_pixel(t_pix_mix mix);
        case (mix)
            PX_LOW:    return PIX_W'($urandom_range(0, 3));
            PX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PX_SPARSE: return ($urandom_range(0, 9) == 0) ? 8'hFF : PIX_W'($urandom_range(0, 15));
            default:   return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_frame(input int len, input t_pix_mix mix);
        for (int i = 0; i < len; i++)
            send_pixel(draw_pixel(mix), i == len - 1);
    endtask

    task automatic send_pixels(input logic [PIX_W-1:0] pix [$]);
        foreach (pix[i])
            send_pixel(pix[i], i == pix.size() - 1);
    endtask

    // config only once the mapper has gone quiet
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (mapper.pending_maps.size() != 0) @(posedge i_clk);
        repeat (MAP_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        mapper.set_coef(idx, data);
    endtask

    task automatic load_coef_set();
        for (int k = 0; k < NUM_COEF; k++)
            write_reg(CFG_IDX_W'(k), coef_set[k]);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] draw_coef(bit perspective);
        logic [63:0] raw;
        int          s;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return ONE_Q24;
            4: return -ONE_Q24;
            5: return raw[COEF_W-1:0];
            default: begin
                // small values keep the denominator near one and the quotient in range
                if (perspective)
                    s = int'($urandom_range(0, 8191)) - 4096;
                else
                    s = int'($urandom) >>> 4;
                return COEF_W'(s);
            end
        endcase
    endfunction

    initial begin
        int               px_count;
        int               frames;
        int               len;

        mapper = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity mapping from reset: dark frame, single bright pixel, ties, max on last
        send_pixels('{8'd0});
        send_pixels('{8'd255});
        send_pixels('{8'd0, 8'd7, 8'd3, 8'd7, 8'd2});
        send_pixels('{8'd5, 8'd5, 8'd5});
        send_pixels('{8'd1, 8'd9, 8'd200});
        wait_quiet();

        // zero denominator at column 1, saturation both ways at column 2
        coef_set[COEF_XX] = COEF_MAX;
        coef_set[COEF_XY] = ONE_Q24;
        coef_set[COEF_XT] = COEF_W'(32'h0123_4567);
        coef_set[COEF_YX] = COEF_MIN;
        coef_set[COEF_YY] = -ONE_Q24;
        coef_set[COEF_YT] = COEF_MIN;
        coef_set[COEF_ZX] = -ONE_Q24;
        coef_set[COEF_ZY] = COEF_MAX;
        load_coef_set();
        // indexes past the coefficient file must be ignored
        write_reg(IDX_UNUSED_LO, COEF_MAX);
        write_reg(IDX_UNUSED_HI, '1);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_pixels('{8'd0, 8'd255});
        send_pixels('{8'd0, 8'd0, 8'd255});
        send_pixels('{8'd255});
        send_pixels('{8'd3, 8'd200, 8'd200});
        wait_quiet();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            for (int k = 0; k < NUM_COEF; k++)
                coef_set[k] = draw_coef(k == COEF_ZX || k == COEF_ZY);
            load_coef_set();
            idle_on = (ph != 3) && (ph != RAND_PHASES - 1);
            if (ph == 2)
                long_hold_req <= 1'b1;
            px_count = 0;
            frames   = 0;
            while (px_count < PHASE_PIXELS || frames < PHASE_FRAMES) begin
                len = $urandom_range(1, 12);
                send_frame(len, t_pix_mix'($urandom_range(0, 3)));
                px_count += len;
                frames++;
            end
            wait_quiet();
        end

        if (mapper.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bshm_pkg.sv
hw/rtl/bshm_tracker.sv
hw/rtl/bshm_ctrl.sv
hw/rtl/bshm_map_dp.sv
hw/rtl/bright_spot_homography_mapper_core.sv
sim/tb_bright_spot_homography_mapper_core.sv
